FILE: hw/rtl/urc_pkg.sv
// shared types and constants of the ultrasonic ranging controller
package urc_pkg;

	// register indexes of the configuration port
	localparam logic [1:0] REG_TIMEOUT_US   = 2'd0;
	localparam logic [1:0] REG_SAMPLE_COUNT = 2'd1;
	localparam logic [1:0] REG_GAP_MS       = 2'd2;
	localparam logic [1:0] REG_UNIT_MM      = 2'd3;

	// reset values of the configuration registers
	localparam logic [15:0] TIMEOUT_RST = 16'd27840;
	localparam logic [7:0]  COUNT_RST   = 8'd1;
	localparam logic [15:0] GAP_RST     = 16'd60;

	// datapath widths
	localparam int unsigned TICK_W = 17;
	localparam int unsigned SUM_W  = 24;
	localparam int unsigned NUM_W  = 32;
	localparam int unsigned DEN_W  = 14;
	localparam int unsigned DIST_W = 18;
	localparam int unsigned CNT_W  = $clog2(NUM_W);

	// echo ticks per centimetre
	localparam logic [DEN_W-1:0] TICKS_PER_CM = 14'd58;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_PRELOW,
		PH_TRIGHI,
		PH_WAITRISE,
		PH_MEASURE,
		PH_GAP
	} phase_t;

	typedef struct packed {
		logic [15:0] timeout_us;
		logic [7:0]  sample_count;
		logic [15:0] gap_ms;
		logic        unit_mm;
	} cfg_t;

	// per-tick result of the sequencer
	typedef struct packed {
		logic trig;
		logic busy;
		logic done;
	} tick_res_t;

	// totals handed to the divider at the end of a round
	typedef struct packed {
		logic [SUM_W-1:0] width_sum;
		logic [7:0]       good_count;
		logic             unit_mm;
	} round_end_t;

	typedef struct packed {
		logic              valid;
		logic [DIST_W-1:0] distance;
	} div_res_t;

endpackage

FILE: hw/rtl/ultrasonic_ranging_controller_core.sv
// Ultrasonic ranging controller: one input transaction per microsecond tick,
// one output transaction per tick. An ordinary tick's result is shown from
// the output register in the cycle after it is taken; a new tick is taken
// once that register is empty or as its output is taken. A round's last tick
// waits for the averaged distance from a restoring divider that settles one
// of the 32 quotient bits per cycle, and the done transaction enters the
// output register when the divider signals done. No tick is taken while the
// divider runs. The sensor tick rate is set by the upstream source, not this block.
module ultrasonic_ranging_controller_core #(
	parameter int unsigned TRIG_TICKS    = 15,
	parameter int unsigned PRE_LOW_TICKS = 2,
	parameter int unsigned TICKS_PER_MS  = 1000
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// tick input
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [0] start_req, [1] echo_level, [7:2] zero
	// tick result
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [0] trig_level, [1] busy_res, [19:2] distance
	output logic        m_axis_tlast,  // done_res
	output logic        m_axis_tuser   // valid_res
);

	urc_pkg::cfg_t                 cfg_q;
	urc_pkg::tick_res_t            tick_res;
	urc_pkg::round_end_t           round_end;
	urc_pkg::div_res_t             div_res;
	logic                          tick_en;
	logic                          div_busy;
	logic                          div_done;
	logic                          div_start;
	logic                          mvalid_q;
	logic                          trig_q;
	logic                          busy_q;
	logic                          done_q;
	logic                          valid_q;
	logic [urc_pkg::DIST_W-1:0]    dist_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_us   <= urc_pkg::TIMEOUT_RST;
			cfg_q.sample_count <= urc_pkg::COUNT_RST;
			cfg_q.gap_ms       <= urc_pkg::GAP_RST;
			cfg_q.unit_mm      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				urc_pkg::REG_TIMEOUT_US:   cfg_q.timeout_us   <= cfg_data;
				urc_pkg::REG_SAMPLE_COUNT: cfg_q.sample_count <= cfg_data[7:0];
				urc_pkg::REG_GAP_MS:       cfg_q.gap_ms       <= cfg_data;
				urc_pkg::REG_UNIT_MM:      cfg_q.unit_mm      <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// take a tick only with the divider idle, its result stored, and room in the output register
	assign s_axis_tready = !div_busy && !div_done && (!mvalid_q || m_axis_tready);
	assign tick_en       = s_axis_tvalid && s_axis_tready;
	assign div_start     = tick_en && tick_res.done;

	urc_seq #(
		.TRIG_TICKS    (TRIG_TICKS),
		.PRE_LOW_TICKS (PRE_LOW_TICKS),
		.TICKS_PER_MS  (TICKS_PER_MS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_en    (tick_en),
		.start_req  (s_axis_tdata[0]),
		.echo_level (s_axis_tdata[1]),
		.cfg        (cfg_q),
		.tick_res   (tick_res),
		.round_end  (round_end)
	);

	urc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.round_end (round_end),
		.busy      (div_busy),
		.done      (div_done),
		.res       (div_res)
	);

	// output register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_q <= 1'b0;
		end else if (tick_en && !tick_res.done) begin
			mvalid_q <= 1'b1;
		end else if (div_done) begin
			mvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			mvalid_q <= 1'b0;
		end
	end

	// output payload: plain ticks at once, the done tick when the divider ends
	always_ff @(posedge clk) begin
		if (tick_en && !tick_res.done) begin
			trig_q  <= tick_res.trig;
			busy_q  <= tick_res.busy;
			done_q  <= 1'b0;
			valid_q <= 1'b0;
			dist_q  <= '0;
		end else if (div_start) begin
			trig_q <= tick_res.trig;
			busy_q <= tick_res.busy;
		end else if (div_done) begin
			done_q  <= 1'b1;
			valid_q <= div_res.valid;
			dist_q  <= div_res.distance;
		end
	end

	assign m_axis_tvalid = mvalid_q;
	assign m_axis_tdata  = {4'd0, dist_q, busy_q, trig_q};
	assign m_axis_tlast  = done_q;
	assign m_axis_tuser  = valid_q;

endmodule

FILE: hw/rtl/urc_seq.sv
// tick sequencer: trigger pulse, echo timing, sample gap and round totals
module urc_seq #(
	parameter int unsigned TRIG_TICKS    = 15,
	parameter int unsigned PRE_LOW_TICKS = 2,
	parameter int unsigned TICKS_PER_MS  = 1000
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   tick_en,
	input  logic                   start_req,
	input  logic                   echo_level,
	input  urc_pkg::cfg_t          cfg,
	output urc_pkg::tick_res_t     tick_res,
	output urc_pkg::round_end_t    round_end
);

	urc_pkg::phase_t                 phase_q, phase_cur, phase_n;
	logic [urc_pkg::TICK_W-1:0]      tick_q, tick_cur, tick_n;
	logic [15:0]                     ms_q, ms_cur, ms_n;
	logic [7:0]                      sidx_q, sidx_cur, sidx_n;
	logic [7:0]                      good_q, good_cur, good_n;
	logic [urc_pkg::SUM_W-1:0]       sum_q, sum_cur, sum_n;
	logic                            start_go;
	logic                            round_over;

	// a start request in idle clears the round and opens the pre-low phase
	assign start_go  = (phase_q == urc_pkg::PH_IDLE) && start_req;
	assign phase_cur = start_go ? urc_pkg::PH_PRELOW : phase_q;
	assign tick_cur  = start_go ? '0 : tick_q;
	assign ms_cur    = start_go ? '0 : ms_q;
	assign sidx_cur  = start_go ? '0 : sidx_q;
	assign good_cur  = start_go ? '0 : good_q;
	assign sum_cur   = start_go ? '0 : sum_q;

	// next state and counters for this tick
	always_comb begin
		logic [urc_pkg::TICK_W-1:0] tick_inc;
		logic [15:0]                ms_inc;
		logic                       smp_end;
		logic                       smp_good;
		phase_n    = phase_cur;
		tick_n     = tick_cur;
		ms_n       = ms_cur;
		sidx_n     = sidx_cur;
		good_n     = good_cur;
		sum_n      = sum_cur;
		smp_end    = 1'b0;
		smp_good   = 1'b0;
		round_over = 1'b0;
		tick_inc   = tick_cur + urc_pkg::TICK_W'(1);
		ms_inc     = ms_cur;
		unique case (phase_cur)
			urc_pkg::PH_IDLE: begin
			end
			urc_pkg::PH_PRELOW: begin
				if (tick_inc >= urc_pkg::TICK_W'(PRE_LOW_TICKS)) begin
					tick_n  = '0;
					phase_n = urc_pkg::PH_TRIGHI;
				end else begin
					tick_n = tick_inc;
				end
			end
			urc_pkg::PH_TRIGHI: begin
				if (tick_inc >= urc_pkg::TICK_W'(TRIG_TICKS)) begin
					tick_n  = '0;
					phase_n = urc_pkg::PH_WAITRISE;
				end else begin
					tick_n = tick_inc;
				end
			end
			urc_pkg::PH_WAITRISE: begin
				if (echo_level) begin
					// the rise tick already counts as width one
					tick_n  = urc_pkg::TICK_W'(1);
					phase_n = urc_pkg::PH_MEASURE;
					smp_end = urc_pkg::TICK_W'(1) > {1'b0, cfg.timeout_us};
				end else begin
					tick_n  = tick_inc;
					smp_end = tick_inc > {1'b0, cfg.timeout_us};
				end
			end
			urc_pkg::PH_MEASURE: begin
				if (echo_level) begin
					tick_n  = tick_inc;
					smp_end = tick_inc > {1'b0, cfg.timeout_us};
				end else begin
					smp_end  = 1'b1;
					smp_good = tick_cur != '0;
				end
			end
			urc_pkg::PH_GAP: begin
				if (tick_inc >= urc_pkg::TICK_W'(TICKS_PER_MS)) begin
					tick_inc = '0;
					ms_inc   = ms_cur + 16'd1;
				end
				if (ms_inc >= cfg.gap_ms) begin
					tick_n  = '0;
					ms_n    = '0;
					phase_n = urc_pkg::PH_PRELOW;
				end else begin
					tick_n = tick_inc;
					ms_n   = ms_inc;
				end
			end
			default: begin
				phase_n = urc_pkg::PH_IDLE;
			end
		endcase

		// close the sample; the round ends after the last one or on index wrap
		if (smp_end) begin
			if (smp_good) begin
				sum_n  = sum_cur + urc_pkg::SUM_W'(tick_cur);
				good_n = good_cur + 8'd1;
			end
			sidx_n = sidx_cur + 8'd1;
			tick_n = '0;
			ms_n   = '0;
			if ((sidx_n >= cfg.sample_count) || (sidx_n == 8'd0)) begin
				round_over = 1'b1;
				phase_n    = urc_pkg::PH_IDLE;
			end else if (cfg.gap_ms == 16'd0) begin
				phase_n = urc_pkg::PH_PRELOW;
			end else begin
				phase_n = urc_pkg::PH_GAP;
			end
		end
	end

	// per-tick outputs
	always_comb begin
		tick_res.trig        = phase_cur == urc_pkg::PH_TRIGHI;
		tick_res.busy        = phase_cur != urc_pkg::PH_IDLE;
		tick_res.done        = round_over;
		round_end.width_sum  = sum_n;
		round_end.good_count = good_n;
		round_end.unit_mm    = cfg.unit_mm;
	end

	// state update once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= urc_pkg::PH_IDLE;
			tick_q  <= '0;
			ms_q    <= '0;
			sidx_q  <= '0;
			good_q  <= '0;
			sum_q   <= '0;
		end else if (tick_en) begin
			phase_q <= phase_n;
			tick_q  <= tick_n;
			ms_q    <= ms_n;
			sidx_q  <= sidx_n;
			good_q  <= good_n;
			sum_q   <= sum_n;
		end
	end

endmodule

FILE: hw/rtl/urc_div.sv
// restoring divider, one quotient bit per cycle, for the averaged distance
module urc_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  urc_pkg::round_end_t  round_end,
	output logic                 busy,
	output logic                 done,
	output urc_pkg::div_res_t    res
);

	logic                          busy_q;
	logic                          done_q;
	logic [urc_pkg::CNT_W-1:0]     cnt_q;
	logic [urc_pkg::DEN_W-1:0]     rem_q;
	logic [urc_pkg::NUM_W-1:0]     quo_q;
	logic [urc_pkg::DEN_W-1:0]     den_q;
	logic                          valid_q;
	logic [urc_pkg::NUM_W-1:0]     num_in;
	logic [urc_pkg::DEN_W-1:0]     den_in;
	logic [urc_pkg::DEN_W:0]       rem_sh;
	logic                          q_bit;

	// sixteenths: width_sum * 16 for cm, * 160 (128 + 32) for mm
	always_comb begin
		logic [urc_pkg::NUM_W-1:0] sum_ext;
		sum_ext = urc_pkg::NUM_W'(round_end.width_sum);
		if (round_end.unit_mm) begin
			num_in = (sum_ext << 7) + (sum_ext << 5);
		end else begin
			num_in = sum_ext << 4;
		end
		den_in = urc_pkg::DEN_W'(urc_pkg::DEN_W'(round_end.good_count)
			* urc_pkg::TICKS_PER_CM);
	end

	// one shift and trial subtract
	assign rem_sh = {rem_q, quo_q[urc_pkg::NUM_W-1]};
	assign q_bit  = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + urc_pkg::CNT_W'(1);
				if (cnt_q == urc_pkg::CNT_W'(urc_pkg::NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand and partial remainder registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= '0;
			quo_q   <= num_in;
			den_q   <= den_in;
			valid_q <= round_end.good_count != 8'd0;
		end else if (busy_q) begin
			rem_q <= q_bit ? urc_pkg::DEN_W'(rem_sh - {1'b0, den_q})
				: urc_pkg::DEN_W'(rem_sh);
			quo_q <= {quo_q[urc_pkg::NUM_W-2:0], q_bit};
		end
	end

	assign busy         = busy_q;
	assign done         = done_q;
	assign res.valid    = valid_q;
	assign res.distance = valid_q ? quo_q[urc_pkg::DIST_W-1:0] : '0;

endmodule

FILE: hw/rtl/urc_checker.sv
// port-level checks of the ranging controller, bound to the top level
module urc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        m_axis_tuser
);

	// a held result keeps its payload until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("output transaction changed while stalled");

	// distance and valid only appear on the done transaction
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !m_axis_tuser && m_axis_tdata[19:2] == 18'd0)
		else $error("distance or valid outside the done transaction");

	// the done transaction is a busy tick with the trigger low
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[1] && !m_axis_tdata[0])
		else $error("done transaction without busy or with trigger high");

	// the trigger only fires inside a round
	a_trig_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
		else $error("trigger high outside a round");

	// a tick is never taken while a result is stuck in the output register
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !(s_axis_tvalid && s_axis_tready))
		else $error("tick accepted while the output is stalled");

endmodule

bind ultrasonic_ranging_controller_core urc_checker u_urc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);

FILE: dv/tb_ultrasonic_ranging_controller_core.sv
// self-checking testbench for the ultrasonic ranging controller core
module tb_ultrasonic_ranging_controller_core;
	import urc_pkg::*;

	localparam int unsigned PRE_LOW_LEN   = 2;
	localparam int unsigned TRIG_LEN      = 15;
	localparam int unsigned US_PER_MS     = 1000;
	localparam int unsigned RANDOM_TICKS  = 150;
	localparam int unsigned PRESSURE_HOLD = 300;
	localparam int unsigned DRAIN_CYCLES  = 40;
	localparam int unsigned RUN_LIMIT     = 5_000_000;

	// one result transaction as the sensor logic sees it
	typedef struct packed {
		logic              trig;
		logic              busy;
		logic              done;
		logic              valid;
		logic [DIST_W-1:0] distance;
	} tick_out_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_we        = 1'b0;
	logic [1:0]  cfg_index     = REG_TIMEOUT_US;
	logic [15:0] cfg_data      = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;  // [0] start_req, [1] echo_level, [7:2] zero
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // [0] trig_level, [1] busy_res, [19:2] distance
	logic        m_axis_tlast;        // done_res
	logic        m_axis_tuser;        // valid_res

	ultrasonic_ranging_controller_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #2 clk = ~clk;

	// settings and round state as the testbench tracks them
	logic [15:0]       cfg_timeout = TIMEOUT_RST;
	logic [7:0]        cfg_count   = COUNT_RST;
	logic [15:0]       cfg_gap     = GAP_RST;
	logic              cfg_mm      = 1'b0;
	phase_t            rng_phase   = PH_IDLE;
	logic [TICK_W-1:0] rng_ticks   = '0;
	logic [15:0]       rng_ms      = '0;
	logic [7:0]        rng_index   = '0;
	logic [7:0]        rng_good    = '0;
	logic [SUM_W-1:0]  rng_sum     = '0;
	logic [DIST_W-1:0] rng_dist    = '0;

	tick_out_t   predicted_ticks[$];
	int unsigned ticks_sent    = 0;
	int unsigned mismatches    = 0;
	int unsigned burst_left    = 8;
	bit          sender_gaps   = 1'b1;
	logic        pressure_req  = 1'b0;
	logic        pressure_done = 1'b0;
	int unsigned hold_left     = 0;
	logic [9:0]  rx_cycle      = '0;

	// close one sample; returns 1 when the round is over
	function automatic bit close_sample(input bit good, input logic [TICK_W-1:0] width);
		logic [63:0] num;
		logic [63:0] den;
		if (good) begin
			rng_sum  = rng_sum + SUM_W'(width);
			rng_good = rng_good + 8'd1;
		end
		rng_index = rng_index + 8'd1;
		rng_ticks = '0;
		rng_ms    = '0;
		if (rng_index >= cfg_count || rng_index == 8'd0) begin
			if (rng_good == 8'd0) begin
				rng_dist = '0;
			end else begin
				// floor of average width over ticks per cm, in sixteenths
				num = 64'(rng_sum) * (cfg_mm ? 64'd160 : 64'd16);
				den = 64'(rng_good) * 64'(TICKS_PER_CM);
				rng_dist = DIST_W'(num / den);
			end
			rng_phase = PH_IDLE;
			return 1'b1;
		end
		rng_phase = (cfg_gap == 16'd0) ? PH_PRELOW : PH_GAP;
		return 1'b0;
	endfunction

	// advance the tracked state by one microsecond tick
	function automatic tick_out_t ranging_tick(input logic start, input logic echo);
		tick_out_t r;
		logic      done;
		r    = '0;
		done = 1'b0;
		if (rng_phase == PH_IDLE && start) begin
			rng_index = '0;
			rng_good  = '0;
			rng_sum   = '0;
			rng_ticks = '0;
			rng_ms    = '0;
			rng_phase = PH_PRELOW;
		end
		r.busy = (rng_phase != PH_IDLE);
		case (rng_phase)
			PH_PRELOW: begin
				rng_ticks = rng_ticks + 1'b1;
				if (rng_ticks >= PRE_LOW_LEN) begin
					rng_ticks = '0;
					rng_phase = PH_TRIGHI;
				end
			end
			PH_TRIGHI: begin
				r.trig    = 1'b1;
				rng_ticks = rng_ticks + 1'b1;
				if (rng_ticks >= TRIG_LEN) begin
					rng_ticks = '0;
					rng_phase = PH_WAITRISE;
				end
			end
			PH_WAITRISE: begin
				// the first high tick already counts as width one
				if (echo) begin
					rng_ticks = TICK_W'(1);
					rng_phase = PH_MEASURE;
				end else begin
					rng_ticks = rng_ticks + 1'b1;
				end
				if (rng_ticks > cfg_timeout)
					done = close_sample(1'b0, '0);
			end
			PH_MEASURE: begin
				if (echo) begin
					rng_ticks = rng_ticks + 1'b1;
					if (rng_ticks > cfg_timeout)
						done = close_sample(1'b0, '0);
				end else begin
					done = close_sample(rng_ticks != '0, rng_ticks);
				end
			end
			PH_GAP: begin
				rng_ticks = rng_ticks + 1'b1;
				if (rng_ticks >= US_PER_MS) begin
					rng_ticks = '0;
					rng_ms    = rng_ms + 16'd1;
				end
				if (rng_ms >= cfg_gap) begin
					rng_ticks = '0;
					rng_ms    = '0;
					rng_phase = PH_PRELOW;
				end
			end
			default: rng_phase = PH_IDLE;
		endcase
		r.done     = done;
		r.valid    = done && rng_good != 8'd0;
		r.distance = done ? rng_dist : '0;
		return r;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// offer one tick, record its prediction once the transaction completes
	task automatic send_tick(input logic start, input logic echo);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'b0, echo, start};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predicted_ticks.push_back(ranging_tick(start, echo));
		ticks_sent++;
		if (burst_left != 0)
			burst_left--;
		// end of a burst: pause the stream for a while
		if (sender_gaps && burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 16);
		end
	endtask

	task automatic idle_ticks(input int unsigned n);
		repeat (n) send_tick(1'b0, 1'($urandom_range(0, 1)));
	endtask

	// one measurement round; each sample gets a random rise delay and echo width
	task automatic run_round(input bit noisy, input int unsigned rise_lo, input int unsigned rise_hi,
			input int unsigned w_lo, input int unsigned w_hi);
		int unsigned low_left;
		int unsigned high_left;
		logic        echo;
		low_left  = 0;
		high_left = 0;
		send_tick(1'b1, 1'($urandom_range(0, 1)));
		while (rng_phase != PH_IDLE) begin
			echo = 1'($urandom_range(0, 1));
			case (rng_phase)
				PH_TRIGHI: begin
					low_left  = $urandom_range(rise_lo, rise_hi);
					high_left = $urandom_range(w_lo, w_hi) - 1;
				end
				PH_WAITRISE: begin
					if (low_left != 0) begin
						echo = 1'b0;
						low_left--;
					end else begin
						echo = 1'b1;
					end
				end
				PH_MEASURE: begin
					if (high_left != 0) begin
						echo = 1'b1;
						high_left--;
					end else begin
						echo = 1'b0;
					end
				end
				default: ;
			endcase
			if (noisy && $urandom_range(0, 7) == 0)
				echo = ~echo;
			// start is ignored while a round runs
			send_tick(1'($urandom_range(0, 1)), echo);
		end
	endtask

	task automatic wait_results_drained();
		s_axis_tvalid <= 1'b0;
		while (predicted_ticks.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// registers change only with the block idle and all results in
	task automatic write_config(input logic [15:0] t, input logic [7:0] count,
			input logic [15:0] gap, input logic mm);
		wait_results_drained();
		write_reg(REG_TIMEOUT_US, t);
		write_reg(REG_SAMPLE_COUNT, 16'(count));
		write_reg(REG_GAP_MS, gap);
		write_reg(REG_UNIT_MM, 16'(mm));
		cfg_timeout = t;
		cfg_count   = count;
		cfg_gap     = gap;
		cfg_mm      = mm;
	endtask

	task automatic test_directed_cases();
		// reset settings: single sample, centimetres
		idle_ticks(3);
		run_round(1'b0, 0, 0, 1, 1);
		// shortest timeout, sample count zero acts as one, no gap
		write_config(16'd1, 8'd0, 16'd0, 1'b0);
		run_round(1'b0, 0, 0, 1, 1);
		// echo rises too late
		run_round(1'b0, 2, 2, 1, 1);
		// echo stays high too long
		run_round(1'b0, 0, 0, 2, 2);
		// rise right at the timeout
		run_round(1'b0, 1, 1, 1, 1);
		// every sample fails: no valid distance
		write_config(16'd1, 8'd2, 16'd0, 1'b1);
		run_round(1'b0, 2, 2, 1, 1);
		// back-to-back samples in millimetres, some failing
		write_config(16'd6, 8'd4, 16'd0, 1'b1);
		run_round(1'b0, 0, 7, 1, 7);
		// longest timeout and gap, one long echo
		write_config(16'hFFFF, 8'd1, 16'hFFFF, 1'b1);
		run_round(1'b0, 0, 3, 60, 60);
		idle_ticks(2);
	endtask

	// one millisecond pause between two samples
	task automatic test_long_gap();
		write_config(16'd30, 8'd2, 16'd1, 1'b0);
		run_round(1'b1, 0, 12, 1, 12);
	endtask

	// several back-to-back samples averaged in millimetres
	task automatic test_many_samples();
		write_config(16'd2, 8'd8, 16'd0, 1'b1);
		run_round(1'b0, 0, 3, 1, 3);
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_back_pressure();
		write_config(16'd20, 8'd3, 16'd0, 1'b0);
		sender_gaps = 1'b0;
		pressure_req <= 1'b1;
		run_round(1'b0, 0, 20, 1, 20);
		sender_gaps = 1'b1;
	endtask

	task automatic test_random_rounds();
		int unsigned first_tick;
		int unsigned lim;
		logic [15:0] t;
		logic [15:0] gap;
		logic [7:0]  count;
		first_tick = ticks_sent;
		while (ticks_sent - first_tick < RANDOM_TICKS) begin
			case ($urandom_range(0, 9))
				0:       t = 16'hFFFF;
				1:       t = 16'd1;
				2:       t = 16'($urandom_range(17, 65534));
				default: t = 16'($urandom_range(1, 16));
			endcase
			case ($urandom_range(0, 9))
				0:       count = 8'd0;
				1:       count = 8'($urandom_range(5, 8));
				default: count = 8'($urandom_range(1, 4));
			endcase
			// any gap value is fine when the pause is never entered
			gap = (count > 8'd1) ? 16'd0 : 16'($urandom);
			write_config(t, count, gap, 1'($urandom_range(0, 1)));
			lim = (t > 16) ? 16 : t;
			repeat ($urandom_range(1, 3)) begin
				idle_ticks($urandom_range(0, 3));
				run_round($urandom_range(0, 4) == 0, 0, lim + $urandom_range(0, 1),
					1, lim + $urandom_range(0, 1));
			end
		end
	endtask

	// result check and receiver stall pattern
	always @(posedge clk) begin : result_check
		tick_out_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (predicted_ticks.size() == 0) begin
					$error("result transaction with no tick outstanding");
					mismatches++;
				end else begin
					want = predicted_ticks.pop_front();
					check_field("trig_level", want.trig, m_axis_tdata[0]);
					check_field("busy_res", want.busy, m_axis_tdata[1]);
					check_field("distance", want.distance, m_axis_tdata[19:2]);
					check_field("done_res", want.done, m_axis_tlast);
					check_field("valid_res", want.valid, m_axis_tuser);
				end
			end
			rx_cycle <= rx_cycle + 10'd1;
			if (hold_left != 0) begin
				m_axis_tready <= 1'b0;
				hold_left     <= hold_left - 1;
			end else if (pressure_req && !pressure_done) begin
				m_axis_tready <= 1'b0;
				hold_left     <= PRESSURE_HOLD;
				pressure_done <= 1'b1;
			end else begin
				case (rx_cycle[9:8])
					2'd0:    m_axis_tready <= 1'b1;
					2'd1:    m_axis_tready <= (rx_cycle[1:0] != 2'd3);
					2'd2:    m_axis_tready <= ($urandom_range(0, 2) != 0);
					default: m_axis_tready <= rx_cycle[2];
				endcase
			end
		end
	end

	// run limit
	initial begin
		#(RUN_LIMIT);
		$display("ultrasonic_ranging_controller_core verification failed");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_long_gap();
		test_many_samples();
		test_back_pressure();
		test_random_rounds();
		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("ultrasonic_ranging_controller_core verification clean");
		end else begin
			$display("ultrasonic_ranging_controller_core verification failed");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/urc_pkg.sv
hw/rtl/urc_seq.sv
hw/rtl/urc_div.sv
hw/rtl/ultrasonic_ranging_controller_core.sv
hw/rtl/urc_checker.sv
dv/tb_ultrasonic_ranging_controller_core.sv
